// ===== rtl/core/rgba_ppm_pkg.sv =====
// Shared types, ASCII codes and the divide-by-ten and digit-count helpers for the PPM encoder.
// No dependencies; used by the decimal converter, the sequencer and the top level.
`default_nettype none

package rgba_ppm_pkg;

    localparam int DEC_DIGITS = 5;

    // configuration register indexes
    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    // header characters
    localparam logic [7:0] ASCII_P     = 8'h50;
    localparam logic [7:0] ASCII_6     = 8'h36;
    localparam logic [7:0] ASCII_2     = 8'h32;
    localparam logic [7:0] ASCII_5     = 8'h35;
    localparam logic [7:0] ASCII_0     = 8'h30;
    localparam logic [7:0] ASCII_LF    = 8'h0A;
    localparam logic [7:0] ASCII_SPACE = 8'h20;

    // pixel byte slots
    localparam logic [2:0] SLOT_RED   = 3'd0;
    localparam logic [2:0] SLOT_GREEN = 3'd1;
    localparam logic [2:0] SLOT_BLUE  = 3'd2;

    typedef enum logic [5:0] {
        ST_PIX  = 6'b000001,
        ST_PRE  = 6'b000010,
        ST_WDIG = 6'b000100,
        ST_SP   = 6'b001000,
        ST_HDIG = 6'b010000,
        ST_POST = 6'b100000
    } t_state;

    typedef struct packed {
        logic                           done;
        logic [DEC_DIGITS-1:0][3:0]     w_dig;   // index 0 is the units digit
        logic [2:0]                     w_num;   // significant digits, 1..5
        logic [DEC_DIGITS-1:0][3:0]     h_dig;
        logic [2:0]                     h_num;
    } t_dec_res;

    typedef struct packed {
        logic       valid;
        logic [7:0] data;
        logic       last;
        logic       eoi;
    } t_emit;

    typedef struct packed {
        logic [15:0] quo;
        logic [3:0]  dig;
    } t_div10;

    // x / 10 as a multiply by the reciprocal, exact for all 16-bit x
    function automatic t_div10 div10(input logic [15:0] x);
        logic [32:0] prod;
        logic [16:0] back;
        t_div10      res;
        prod    = {17'd0, x} * 33'd52429;
        res.quo = {2'd0, prod[32:19]};
        back    = {res.quo[13:0], 3'd0} + {2'd0, res.quo[13:0], 1'b0};
        res.dig = 4'(x - back[15:0]);
        return res;
    endfunction

    // number of significant decimal digits, zero counts as one digit
    function automatic logic [2:0] dig_count(input logic [DEC_DIGITS-1:0][3:0] d);
        logic [2:0] n;
        if (d[4] != 4'd0)      n = 3'd5;
        else if (d[3] != 4'd0) n = 3'd4;
        else if (d[2] != 4'd0) n = 3'd3;
        else if (d[1] != 4'd0) n = 3'd2;
        else                   n = 3'd1;
        return n;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/rgba_ppm_dec.sv =====
// Binary to decimal converter for the header's width and height.
// Depends on rgba_ppm_pkg; one digit per lane per cycle, five digits per lane.
`default_nettype none

module rgba_ppm_dec (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire                      i_start,
    input  wire [15:0]               i_width,
    input  wire [15:0]               i_height,
    output rgba_ppm_pkg::t_dec_res   o_res
);

    logic [2:0]                                 r_cnt, n_cnt;
    logic [15:0]                                r_xw, r_xh;
    logic [rgba_ppm_pkg::DEC_DIGITS-1:0][3:0]   r_dw, r_dh;
    rgba_ppm_pkg::t_div10                       w_qw, w_qh;

    assign w_qw = rgba_ppm_pkg::div10(r_xw);
    assign w_qh = rgba_ppm_pkg::div10(r_xh);

    always_comb begin
        n_cnt = r_cnt;
        if (i_start) begin
            n_cnt = 3'(rgba_ppm_pkg::DEC_DIGITS);
        end else if (r_cnt != 3'd0) begin
            n_cnt = r_cnt - 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 3'd0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    // shift digits in from the top so the units digit ends at index 0
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_xw <= i_width;
            r_xh <= i_height;
        end else if (r_cnt != 3'd0) begin
            r_xw <= w_qw.quo;
            r_xh <= w_qh.quo;
            r_dw <= {w_qw.dig, r_dw[rgba_ppm_pkg::DEC_DIGITS-1:1]};
            r_dh <= {w_qh.dig, r_dh[rgba_ppm_pkg::DEC_DIGITS-1:1]};
        end
    end

    assign o_res.done  = (r_cnt == 3'd0);
    assign o_res.w_dig = r_dw;
    assign o_res.h_dig = r_dh;
    assign o_res.w_num = rgba_ppm_pkg::dig_count(r_dw);
    assign o_res.h_num = rgba_ppm_pkg::dig_count(r_dh);

endmodule

`default_nettype wire

// ===== rtl/core/rgba_ppm_seq.sv =====
// Byte sequencer: header bytes, pixel bytes, column/row counting.
// Depends on rgba_ppm_pkg and rgba_ppm_dec.
`default_nettype none

module rgba_ppm_seq (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_pix_valid,
    input  wire [23:0]             i_pix_rgb,
    input  wire [15:0]             i_width,
    input  wire [15:0]             i_height,
    input  wire                    i_advance,
    output rgba_ppm_pkg::t_emit    o_emit,
    output logic                   o_consumed
);

    rgba_ppm_pkg::t_state   r_state, n_state;
    logic [2:0]             r_idx, n_idx;
    logic                   r_hdr_pend, n_hdr_pend;
    logic [15:0]            r_col, n_col;
    logic [15:0]            r_row, n_row;
    logic                   w_start;
    logic                   w_col_wrap, w_row_wrap;
    logic [2:0]             w_wsel, w_hsel;
    rgba_ppm_pkg::t_dec_res w_dec;

    rgba_ppm_dec u_dec (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_start),
        .i_width  (i_width),
        .i_height (i_height),
        .o_res    (w_dec)
    );

    assign w_col_wrap = ((r_col + 16'd1) == i_width);
    assign w_row_wrap = ((r_row + 16'd1) == i_height);
    // digits go out most significant first
    assign w_wsel = w_dec.w_num - 3'd1 - r_idx;
    assign w_hsel = w_dec.h_num - 3'd1 - r_idx;

    always_comb begin
        n_state      = r_state;
        n_idx        = r_idx;
        n_hdr_pend   = r_hdr_pend;
        n_col        = r_col;
        n_row        = r_row;
        w_start      = 1'b0;
        o_consumed   = 1'b0;
        o_emit.valid = 1'b0;
        o_emit.data  = 8'd0;
        o_emit.last  = 1'b0;
        o_emit.eoi   = 1'b0;

        unique case (r_state)
            rgba_ppm_pkg::ST_PIX: begin
                if (i_pix_valid && r_hdr_pend) begin
                    w_start = 1'b1;
                    n_state = rgba_ppm_pkg::ST_PRE;
                    n_idx   = 3'd0;
                end else if (i_pix_valid) begin
                    o_emit.valid = 1'b1;
                    unique case (r_idx)
                        rgba_ppm_pkg::SLOT_RED:   o_emit.data = i_pix_rgb[7:0];
                        rgba_ppm_pkg::SLOT_GREEN: o_emit.data = i_pix_rgb[15:8];
                        default:                  o_emit.data = i_pix_rgb[23:16];
                    endcase
                    if (r_idx == rgba_ppm_pkg::SLOT_BLUE) begin
                        o_emit.last = 1'b1;
                        o_emit.eoi  = w_col_wrap && w_row_wrap;
                    end
                    if (i_advance) begin
                        if (r_idx == rgba_ppm_pkg::SLOT_BLUE) begin
                            n_idx      = 3'd0;
                            o_consumed = 1'b1;
                            if (w_col_wrap) begin
                                n_col = 16'd0;
                                if (w_row_wrap) begin
                                    n_row      = 16'd0;
                                    n_hdr_pend = 1'b1;
                                end else begin
                                    n_row = r_row + 16'd1;
                                end
                            end else begin
                                n_col = r_col + 16'd1;
                            end
                        end else begin
                            n_idx = r_idx + 3'd1;
                        end
                    end
                end
            end
            rgba_ppm_pkg::ST_PRE: begin
                o_emit.valid = 1'b1;
                unique case (r_idx)
                    3'd0:    o_emit.data = rgba_ppm_pkg::ASCII_P;
                    3'd1:    o_emit.data = rgba_ppm_pkg::ASCII_6;
                    default: o_emit.data = rgba_ppm_pkg::ASCII_LF;
                endcase
                if (i_advance) begin
                    if (r_idx == 3'd2) begin
                        n_idx   = 3'd0;
                        n_state = rgba_ppm_pkg::ST_WDIG;
                    end else begin
                        n_idx = r_idx + 3'd1;
                    end
                end
            end
            rgba_ppm_pkg::ST_WDIG: begin
                o_emit.valid = w_dec.done;
                o_emit.data  = rgba_ppm_pkg::ASCII_0 + {4'd0, w_dec.w_dig[w_wsel]};
                if (i_advance && w_dec.done) begin
                    if (r_idx == w_dec.w_num - 3'd1) begin
                        n_idx   = 3'd0;
                        n_state = rgba_ppm_pkg::ST_SP;
                    end else begin
                        n_idx = r_idx + 3'd1;
                    end
                end
            end
            rgba_ppm_pkg::ST_SP: begin
                o_emit.valid = 1'b1;
                o_emit.data  = rgba_ppm_pkg::ASCII_SPACE;
                if (i_advance) begin
                    n_state = rgba_ppm_pkg::ST_HDIG;
                end
            end
            rgba_ppm_pkg::ST_HDIG: begin
                o_emit.valid = 1'b1;
                o_emit.data  = rgba_ppm_pkg::ASCII_0 + {4'd0, w_dec.h_dig[w_hsel]};
                if (i_advance) begin
                    if (r_idx == w_dec.h_num - 3'd1) begin
                        n_idx   = 3'd0;
                        n_state = rgba_ppm_pkg::ST_POST;
                    end else begin
                        n_idx = r_idx + 3'd1;
                    end
                end
            end
            rgba_ppm_pkg::ST_POST: begin
                o_emit.valid = 1'b1;
                unique case (r_idx)
                    3'd1:    o_emit.data = rgba_ppm_pkg::ASCII_2;
                    3'd2:    o_emit.data = rgba_ppm_pkg::ASCII_5;
                    3'd3:    o_emit.data = rgba_ppm_pkg::ASCII_5;
                    default: o_emit.data = rgba_ppm_pkg::ASCII_LF;
                endcase
                if (i_advance) begin
                    if (r_idx == 3'd4) begin
                        n_idx      = 3'd0;
                        n_hdr_pend = 1'b0;
                        n_state    = rgba_ppm_pkg::ST_PIX;
                    end else begin
                        n_idx = r_idx + 3'd1;
                    end
                end
            end
            default: begin
                n_state = rgba_ppm_pkg::ST_PIX;
                n_idx   = 3'd0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= rgba_ppm_pkg::ST_PIX;
            r_idx      <= 3'd0;
            r_hdr_pend <= 1'b1;
            r_col      <= 16'd0;
            r_row      <= 16'd0;
        end else begin
            r_state    <= n_state;
            r_idx      <= n_idx;
            r_hdr_pend <= n_hdr_pend;
            r_col      <= n_col;
            r_row      <= n_row;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/rgba_to_ppm_stream_encoder.sv =====
// Top level of the RGBA to binary PPM (P6) stream encoder.
// Depends on rgba_ppm_pkg and rgba_ppm_seq (which holds rgba_ppm_dec).
//
//   channel  | dir | tdata (low bit up)                  | tlast       | tuser
//   ---------+-----+-------------------------------------+-------------+------------
//   s (pix)  | in  | red, green, blue, alpha (8 each)    | -           | -
//   m (byte) | out | byte_value (8)                      | last_of_run | end_of_image
//   cfg      | in  | idx 0 image_width, 1 image_height; 16-bit data, write only
//
// Each pixel goes out as three bytes (red, green, blue); the byte-wide output
// register sets that split. The next pixel is taken while blue is handed over.
// The header adds 3 + w + 1 + h + 5 words (w, h = digit counts) plus a wait
// while the decimal converter finishes, once per image.
// Reset (synchronous, active low) empties both registers and arms the header.
// A stall on the output holds the current word and the pixel behind it.
`default_nettype none

module rgba_to_ppm_stream_encoder (
    input  wire         i_clk,
    input  wire         i_rst_n,
    // pixel input
    input  wire         i_s_tvalid,
    output logic        o_s_tready,
    input  wire  [31:0] i_s_tdata,   // [7:0] red, [15:8] green, [23:16] blue, [31:24] alpha
    // byte output
    output logic        o_m_tvalid,
    input  wire         i_m_tready,
    output logic [7:0]  o_m_tdata,   // [7:0] byte_value
    output logic        o_m_tlast,   // last_of_run
    output logic        o_m_tuser,   // [0] end_of_image
    // configuration
    input  wire         i_cfg_we,
    input  wire         i_cfg_idx,
    input  wire  [15:0] i_cfg_data
);

    logic [15:0]         r_image_width;
    logic [15:0]         r_image_height;
    logic                r_pix_valid;
    logic [23:0]         r_pix_rgb;
    logic                r_out_valid;
    logic [7:0]          r_out_byte;
    logic                r_out_last;
    logic                r_out_eoi;
    logic                w_advance;
    logic                w_consumed;
    logic                w_accept;
    rgba_ppm_pkg::t_emit w_emit;

    // output register may load when empty or when its word leaves this cycle
    assign w_advance  = !r_out_valid || i_m_tready;
    // take a new pixel when the holding register is free or its blue goes out now
    assign o_s_tready = !r_pix_valid || w_consumed;
    assign w_accept   = i_s_tvalid && o_s_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width  <= 16'd1;
            r_image_height <= 16'd1;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == rgba_ppm_pkg::REG_WIDTH) begin
                r_image_width <= i_cfg_data;
            end else begin
                r_image_height <= i_cfg_data;
            end
        end
    end

    // pixel holding register; alpha is dropped here
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pix_valid <= 1'b0;
        end else if (w_accept) begin
            r_pix_valid <= 1'b1;
        end else if (w_consumed) begin
            r_pix_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_pix_rgb <= i_s_tdata[23:0];
        end
    end

    rgba_ppm_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pix_valid (r_pix_valid),
        .i_pix_rgb   (r_pix_rgb),
        .i_width     (r_image_width),
        .i_height    (r_image_height),
        .i_advance   (w_advance),
        .o_emit      (w_emit),
        .o_consumed  (w_consumed)
    );

    // output word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= w_emit.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance && w_emit.valid) begin
            r_out_byte <= w_emit.data;
            r_out_last <= w_emit.last;
            r_out_eoi  <= w_emit.eoi;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_byte;
    assign o_m_tlast  = r_out_last;
    assign o_m_tuser  = r_out_eoi;

endmodule

`default_nettype wire

// ===== rtl/core/rgba_ppm_chk.sv =====
// Port-level checker for the PPM encoder, attached by bind to the top level.
// Depends only on the top level's ports.
`default_nettype none

module rgba_ppm_chk (
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        i_s_tvalid,
    input wire        o_s_tready,
    input wire [31:0] i_s_tdata,
    input wire        o_m_tvalid,
    input wire        i_m_tready,
    input wire [7:0]  o_m_tdata,
    input wire        o_m_tlast,
    input wire        o_m_tuser,
    input wire        i_cfg_we,
    input wire        i_cfg_idx,
    input wire [15:0] i_cfg_data
);

    // reset leaves no word out and the pixel side open
    a_reset_state: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid && o_s_tready)
        else $error("encoder not empty after reset");

    // end of image only ever marks a blue byte
    a_eoi_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser |-> o_m_tlast)
        else $error("end_of_image without last_of_run");

    // a held pixel frees its slot only while the output side moves
    a_pixel_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> !o_s_tready || i_m_tready || !o_m_tvalid)
        else $error("pixel slot freed under output stall");

    // a stalled word holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=>
            o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tlast) && $stable(o_m_tuser))
        else $error("output word changed under stall");

endmodule

bind rgba_to_ppm_stream_encoder rgba_ppm_chk u_chk (.*);

`default_nettype wire
